/* sv/gocm_pkg.sv */
// shared constants, types and command/status structs for the group overlap cross match
`timescale 1ns / 1ps
package gocm_pkg;

    // sizing
    localparam int MAX_TARGETS = 1024;
    localparam int MAX_MATCHES = 64;
    localparam int COUNT_BITS  = 24;

    // fixed field widths
    localparam int IDX_W      = 10;
    localparam int GID_W      = 11;
    localparam int TCNT_W     = 11;
    localparam int SIZE_W     = 24;
    localparam int SIG_W      = 16;
    localparam int MODE_W     = 2;
    localparam int MERIT_W    = 48;
    localparam int FRAC_W     = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // derived widths
    localparam int TGT_W   = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
    localparam int FILL_W  = $clog2(MAX_MATCHES + 1);
    localparam int NUM_W   = 2 * COUNT_BITS;
    localparam int DEN_W   = COUNT_BITS + SIZE_W;
    localparam int S2_W    = 2 * SIG_W;
    localparam int RHS_W   = S2_W + SIZE_W;
    localparam int SQ_FRAC = 16;
    localparam int SCMP_W  = (NUM_W + SQ_FRAC > RHS_W) ? NUM_W + SQ_FRAC : RHS_W;
    localparam int DCMP_W  = (NUM_W > DEN_W + FRAC_W) ? NUM_W : DEN_W + FRAC_W;
    localparam int DCNT_W  = $clog2(MERIT_W);

    localparam logic [COUNT_BITS-1:0] CNT_MAX       = '1;
    localparam logic [MERIT_W-1:0]    MERIT_MAX     = '1;
    localparam logic [MERIT_W-1:0]    MERIT_INT_MAX = MERIT_MAX >> FRAC_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNIFICANCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_COUNT = 2'd2;
    localparam logic [TCNT_W-1:0]    TCOUNT_RESET     = 11'd1024;

    // merit modes
    localparam logic [MODE_W-1:0] MM_SHARE_SQ = 2'd0;
    localparam logic [MODE_W-1:0] MM_FRAC     = 2'd1;
    localparam logic [MODE_W-1:0] MM_COUNT    = 2'd2;
    localparam logic [MODE_W-1:0] MM_SUM      = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic acc_size;
        logic acc_part;
        logic rd_part;
        logic hit_inc;
        logic clr_wr;
        logic scan_cap;
        logic scan_rhs;
        logic j_inc;
        logic div_start;
        logic div_sel;
        logic m_direct;
        logic m_take;
        logic m_add;
        logic ins;
        logic emit;
        logic tot_clr;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic              j_last;
        logic              keep;
        logic              sig;
        logic [MODE_W-1:0] mode;
        logic              div_done;
        logic              fill_last;
        logic              part_hit;
        logic              part_last;
        logic              out_free;
    } t_sts;

endpackage

/* sv/gocm_div.sv */
// bit-serial q24 fixed-point divider with saturation
`timescale 1ns / 1ps
module gocm_div
    import gocm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [NUM_W-1:0]   i_num,
    input  logic [DEN_W-1:0]   i_den,
    output logic               o_done,
    output logic [MERIT_W-1:0] o_quo
);

    logic               r_busy;
    logic               r_done;
    logic [DCNT_W-1:0]  r_cnt;
    logic [DEN_W-1:0]   r_rem;
    logic [DEN_W-1:0]   r_den;
    logic [MERIT_W-1:0] r_sh;
    logic [MERIT_W-1:0] r_q;

    logic               w_sat;
    logic [DEN_W:0]     w_trial;
    logic               w_ge;

    // quotient at or above 2^48 (or zero divisor) saturates
    assign w_sat   = DCMP_W'(i_num) >= (DCMP_W'(i_den) << FRAC_W);
    assign w_trial = {r_rem, r_sh[MERIT_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= '0;
                if (w_sat) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DCNT_W'(MERIT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= DEN_W'(i_num >> FRAC_W);
            r_sh  <= MERIT_W'(i_num[FRAC_W-1:0]) << FRAC_W;
            r_q   <= w_sat ? MERIT_MAX : '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? DEN_W'(w_trial - {1'b0, r_den}) : DEN_W'(w_trial);
            r_q   <= {r_q[MERIT_W-2:0], w_ge};
            r_sh  <= r_sh << 1;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

/* sv/gocm_dp.sv */
// datapath: config registers, count and size memories, merit arithmetic, sorted list, output
`timescale 1ns / 1ps
module gocm_dp
    import gocm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [IDX_W-1:0]      i_target_index,
    input  logic [SIZE_W-1:0]     i_target_size,
    input  logic [GID_W-1:0]      i_group_id,
    input  logic                  i_last,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic                  i_ready,
    output logic                  o_valid,
    output logic [IDX_W-1:0]      o_match_index,
    output logic [MERIT_W-1:0]    o_merit,
    output logic                  o_found,
    output logic                  o_final_res
);

    logic [MODE_W-1:0]     r_match_mode;
    logic [SIG_W-1:0]      r_sig;
    logic [TCNT_W-1:0]     r_tcount;

    logic [COUNT_BITS-1:0] r_hit_mem [MAX_TARGETS];
    logic [SIZE_W-1:0]     r_size_mem [MAX_TARGETS];
    logic [COUNT_BITS-1:0] r_hit_q;
    logic [SIZE_W-1:0]     r_sz_q;

    logic [TGT_W-1:0]      r_j;
    logic [COUNT_BITS-1:0] r_tot;
    logic [TGT_W-1:0]      r_paddr;
    logic                  r_phit;
    logic                  r_plast;

    logic [COUNT_BITS-1:0] r_c;
    logic [NUM_W-1:0]      r_c2;
    logic [S2_W-1:0]       r_s2;
    logic [SIZE_W-1:0]     r_sz;
    logic [RHS_W-1:0]      r_rhs;
    logic [DEN_W-1:0]      r_nn;
    logic [MERIT_W-1:0]    r_merit;

    logic [TGT_W-1:0]      r_lidx [MAX_MATCHES];
    logic [MERIT_W-1:0]    r_lmer [MAX_MATCHES];
    logic [FILL_W-1:0]     r_fill;

    logic                  r_ovalid;
    logic [IDX_W-1:0]      r_oidx;
    logic [MERIT_W-1:0]    r_omer;
    logic                  r_ofound;
    logic                  r_ofinal;

    logic [31:0]           w_ntg;
    logic                  w_gid_hit;
    logic [TGT_W-1:0]      w_hit_raddr;
    logic                  w_hit_we;
    logic [TGT_W-1:0]      w_hit_waddr;
    logic [COUNT_BITS-1:0] w_hit_wdata;
    logic                  w_j_last;
    logic [NUM_W-1:0]      w_div_num;
    logic [DEN_W-1:0]      w_div_den;
    logic                  w_div_done;
    logic [MERIT_W-1:0]    w_div_quo;
    logic [MERIT_W:0]      w_msum;
    logic [MAX_MATCHES-1:0] w_ge;
    logic                  w_out_free;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_mode <= MM_SHARE_SQ;
            r_sig        <= '0;
            r_tcount     <= TCOUNT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MATCH_MODE:   r_match_mode <= i_cfg_data[MODE_W-1:0];
                CFG_SIGNIFICANCE: r_sig        <= i_cfg_data[SIG_W-1:0];
                CFG_TARGET_COUNT: r_tcount     <= i_cfg_data[TCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // targets in use and range check of the particle's group
    assign w_ntg     = (32'(r_tcount) < 32'(MAX_TARGETS)) ? 32'(r_tcount) : 32'(MAX_TARGETS);
    assign w_gid_hit = (i_group_id != '0) && (32'(i_group_id) <= w_ntg);
    assign w_j_last  = (r_j == TGT_W'(MAX_TARGETS - 1));

    // hit count memory ports
    assign w_hit_raddr = i_cmd.rd_part ? TGT_W'(i_group_id - 1'b1) : r_j;
    assign w_hit_we    = i_cmd.hit_inc | i_cmd.clr_wr;
    assign w_hit_waddr = i_cmd.hit_inc ? r_paddr : r_j;
    assign w_hit_wdata = !i_cmd.hit_inc ? '0 :
                         (r_hit_q == CNT_MAX) ? r_hit_q : r_hit_q + 1'b1;

    always_ff @(posedge i_clk) begin
        if (w_hit_we) begin
            r_hit_mem[w_hit_waddr] <= w_hit_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit_q <= r_hit_mem[w_hit_raddr];
    end

    // target size memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_size && (32'(i_target_index) < 32'(MAX_TARGETS))) begin
            r_size_mem[TGT_W'(i_target_index)] <= i_target_size;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sz_q <= r_size_mem[r_j];
    end

    // scan pointer and particle total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j   <= '0;
            r_tot <= '0;
        end else begin
            if (i_cmd.j_inc) begin
                r_j <= w_j_last ? '0 : r_j + 1'b1;
            end
            if (i_cmd.tot_clr) begin
                r_tot <= '0;
            end else if (i_cmd.acc_part && (r_tot != CNT_MAX)) begin
                r_tot <= r_tot + 1'b1;
            end
        end
    end

    // particle latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_part) begin
            r_paddr <= TGT_W'(i_group_id - 1'b1);
            r_phit  <= w_gid_hit;
            r_plast <= i_last;
        end
    end

    // significance products, one multiplier level per stage
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_cap) begin
            r_c  <= r_hit_q;
            r_c2 <= NUM_W'(r_hit_q) * NUM_W'(r_hit_q);
            r_s2 <= S2_W'(r_sig) * S2_W'(r_sig);
            r_sz <= r_sz_q;
        end
        if (i_cmd.scan_rhs) begin
            r_rhs <= RHS_W'(r_s2) * RHS_W'(r_sz);
            r_nn  <= DEN_W'(r_tot) * DEN_W'(r_sz);
        end
    end

    // shared divider
    assign w_div_num = i_cmd.div_sel ? NUM_W'(r_c) : r_c2;
    assign w_div_den = i_cmd.div_sel ? DEN_W'(r_tot) : r_nn;

    gocm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    // merit register
    assign w_msum = {1'b0, r_merit} + {1'b0, w_div_quo};

    always_ff @(posedge i_clk) begin
        if (i_cmd.m_direct) begin
            r_merit <= (MERIT_W'(r_c) > MERIT_INT_MAX) ? MERIT_MAX : MERIT_W'(r_c) << FRAC_W;
        end else if (i_cmd.m_take) begin
            if (i_cmd.m_add) begin
                r_merit <= w_msum[MERIT_W] ? MERIT_MAX : w_msum[MERIT_W-1:0];
            end else begin
                r_merit <= w_div_quo;
            end
        end
    end

    // sorted list: entries at or above the new merit stay in place
    always_comb begin
        for (int k = 0; k < MAX_MATCHES; k++) begin
            w_ge[k] = (FILL_W'(k) < r_fill) && (r_lmer[k] >= r_merit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.ins) begin
            if (!w_ge[MAX_MATCHES-1] && (r_fill != FILL_W'(MAX_MATCHES))) begin
                r_fill <= r_fill + 1'b1;
            end
        end else if (i_cmd.emit && (r_fill != '0)) begin
            r_fill <= r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins) begin
            if (!w_ge[0]) begin
                r_lidx[0] <= r_j;
                r_lmer[0] <= r_merit;
            end
            for (int k = 1; k < MAX_MATCHES; k++) begin
                if (!w_ge[k]) begin
                    r_lidx[k] <= w_ge[k-1] ? r_j : r_lidx[k-1];
                    r_lmer[k] <= w_ge[k-1] ? r_merit : r_lmer[k-1];
                end
            end
        end else if (i_cmd.emit) begin
            for (int k = 0; k < MAX_MATCHES - 1; k++) begin
                r_lidx[k] <= r_lidx[k+1];
                r_lmer[k] <= r_lmer[k+1];
            end
        end
    end

    // output register
    assign w_out_free = !r_ovalid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            if (r_fill == '0) begin
                r_oidx   <= '0;
                r_omer   <= '0;
                r_ofound <= 1'b0;
                r_ofinal <= 1'b1;
            end else begin
                r_oidx   <= IDX_W'(r_lidx[0]);
                r_omer   <= r_lmer[0];
                r_ofound <= 1'b1;
                r_ofinal <= (r_fill == FILL_W'(1));
            end
        end
    end

    // status
    always_comb begin
        o_sts.j_last    = w_j_last;
        o_sts.keep      = (32'(r_j) < w_ntg) && (r_hit_q != '0);
        o_sts.sig       = (SCMP_W'(r_c2) << SQ_FRAC) > SCMP_W'(r_rhs);
        o_sts.mode      = r_match_mode;
        o_sts.div_done  = w_div_done;
        o_sts.fill_last = (r_fill <= FILL_W'(1));
        o_sts.part_hit  = r_phit;
        o_sts.part_last = r_plast;
        o_sts.out_free  = w_out_free;
    end

    assign o_valid       = r_ovalid;
    assign o_match_index = r_oidx;
    assign o_merit       = r_omer;
    assign o_found       = r_ofound;
    assign o_final_res   = r_ofinal;

endmodule

/* sv/gocm_ctrl.sv */
// controller state machine: clearing pass, particle update, end-of-group scan, result output
`timescale 1ns / 1ps
module gocm_ctrl
    import gocm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_mode,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_PWR,
        ST_SRD,
        ST_SMUL,
        ST_SRHS,
        ST_SCMP,
        ST_DIVA,
        ST_DIVB,
        ST_INS,
        ST_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_CLR: begin
                o_cmd.clr_wr = 1'b1;
                o_cmd.j_inc  = 1'b1;
                if (i_sts.j_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_cmd.rd_part = 1'b1;
                if (i_valid) begin
                    if (i_mode) begin
                        o_cmd.acc_part = 1'b1;
                        n_state        = ST_PWR;
                    end else begin
                        o_cmd.acc_size = 1'b1;
                    end
                end
            end
            ST_PWR: begin
                o_cmd.hit_inc = i_sts.part_hit;
                n_state       = i_sts.part_last ? ST_SRD : ST_IDLE;
            end
            ST_SRD: begin
                n_state = ST_SMUL;
            end
            ST_SMUL: begin
                // count is cleared as it is read
                o_cmd.scan_cap = 1'b1;
                o_cmd.clr_wr   = 1'b1;
                if (i_sts.keep) begin
                    n_state = ST_SRHS;
                end else begin
                    o_cmd.j_inc   = 1'b1;
                    o_cmd.tot_clr = i_sts.j_last;
                    n_state       = i_sts.j_last ? ST_EMIT : ST_SRD;
                end
            end
            ST_SRHS: begin
                o_cmd.scan_rhs = 1'b1;
                n_state        = ST_SCMP;
            end
            ST_SCMP: begin
                if (!i_sts.sig) begin
                    o_cmd.j_inc   = 1'b1;
                    o_cmd.tot_clr = i_sts.j_last;
                    n_state       = i_sts.j_last ? ST_EMIT : ST_SRD;
                end else begin
                    case (i_sts.mode)
                        MM_COUNT: begin
                            o_cmd.m_direct = 1'b1;
                            n_state        = ST_INS;
                        end
                        MM_FRAC: begin
                            o_cmd.div_start = 1'b1;
                            o_cmd.div_sel   = 1'b1;
                            n_state         = ST_DIVB;
                        end
                        default: begin
                            o_cmd.div_start = 1'b1;
                            n_state         = ST_DIVA;
                        end
                    endcase
                end
            end
            ST_DIVA: begin
                if (i_sts.div_done) begin
                    o_cmd.m_take = 1'b1;
                    if (i_sts.mode == MM_SUM) begin
                        o_cmd.div_start = 1'b1;
                        o_cmd.div_sel   = 1'b1;
                        n_state         = ST_DIVB;
                    end else begin
                        n_state = ST_INS;
                    end
                end
            end
            ST_DIVB: begin
                if (i_sts.div_done) begin
                    o_cmd.m_take = 1'b1;
                    o_cmd.m_add  = (i_sts.mode == MM_SUM);
                    n_state      = ST_INS;
                end
            end
            ST_INS: begin
                o_cmd.ins     = 1'b1;
                o_cmd.j_inc   = 1'b1;
                o_cmd.tot_clr = i_sts.j_last;
                n_state       = i_sts.j_last ? ST_EMIT : ST_SRD;
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.fill_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_ready = (r_state == ST_IDLE);

endmodule

/* sv/group_overlap_cross_match.sv */
// top level of the group overlap cross match: controller, datapath and checks
// After reset the block clears its MAX_TARGETS (1024) hit counters in turn before it
// takes the first item; configuration writes are taken meanwhile. A target size load
// is taken in the idle state; for a particle its counter in the count memory is read
// and written back. The last particle of a source group starts a scan of all 1024
// counter entries: each is read (SRD) and captured (SMUL); one with a hit within
// target_count also has its significance bound formed (SRHS) and tested (SCMP), and
// a match runs its divisions in the bit-serial divider (none in mode 2, one in modes
// 0 and 1, two in mode 3), each ending early on saturation, before it is inserted into
// the sorted list. Results then leave one a cycle while the output side takes them, and the
// next item is accepted after the last result has been moved to the output register.
`timescale 1ns / 1ps
module group_overlap_cross_match
    import gocm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_mode,
    input  logic [IDX_W-1:0]      i_target_index,
    input  logic [SIZE_W-1:0]     i_target_size,
    input  logic [GID_W-1:0]      i_group_id,
    input  logic                  i_last,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [IDX_W-1:0]      o_match_index,
    output logic [MERIT_W-1:0]    o_merit,
    output logic                  o_found,
    output logic                  o_final_res
);

    t_cmd w_cmd;
    t_sts w_sts;

    // control
    gocm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_mode  (i_mode),
        .o_ready (o_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // datapath
    gocm_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_target_index (i_target_index),
        .i_target_size  (i_target_size),
        .i_group_id     (i_group_id),
        .i_last         (i_last),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_match_index  (o_match_index),
        .o_merit        (o_merit),
        .o_found        (o_found),
        .o_final_res    (o_final_res)
    );

`ifndef SYNTH
    // a result is only loaded when the output register is free
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> w_sts.out_free)
        else $error("result loaded over an untaken transfer");

    // a not-found result always closes the source group
    a_notfound_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> o_final_res)
        else $error("not-found result without final flag");

    // merit register has one writer per cycle, and never while inserting
    a_merit_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.m_direct, w_cmd.m_take, w_cmd.ins}))
        else $error("conflicting merit updates");

    // no input is taken while results are pending
    a_no_accept_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> !o_ready)
        else $error("input ready during result output");
`endif

endmodule
